// File: sv/fobq_pkg.sv
// Shared types, constants and microcode table for the biquad cascade lowpass.
`timescale 1ns / 1ps
`default_nettype none

package fobq_pkg;

    // Fixed formats
    localparam int GUARD_BITS = 8;
    localparam int COEF_WIDTH = 32;
    localparam int REG_IDX_W  = 3;
    localparam int UPC_W      = 3;

    // Register indexes on the configuration port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_FIRST_B0  = 3'd1,
        REG_FIRST_A1  = 3'd2,
        REG_FIRST_A2  = 3'd3,
        REG_SECOND_B0 = 3'd4,
        REG_SECOND_A1 = 3'd5,
        REG_SECOND_A2 = 3'd6
    } t_reg_idx;

    // Operation codes of an input item
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Microprogram step addresses
    localparam logic [UPC_W-1:0] STEP_MUL_B0 = 3'd0;
    localparam logic [UPC_W-1:0] STEP_ACC    = 3'd1;
    localparam logic [UPC_W-1:0] STEP_ROUND  = 3'd2;
    localparam logic [UPC_W-1:0] STEP_MUL_A1 = 3'd3;
    localparam logic [UPC_W-1:0] STEP_FB1    = 3'd4;
    localparam logic [UPC_W-1:0] STEP_FB2    = 3'd5;
    localparam logic [UPC_W-1:0] STEP_EMIT   = 3'd6;

    typedef enum logic [1:0] {
        COEF_B0,
        COEF_A1,
        COEF_A2
    } t_coef_sel;

    typedef enum logic {
        SRC_X,
        SRC_Y
    } t_src_sel;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_ACC,
        ALU_ROUND,
        ALU_FB1,
        ALU_FB2
    } t_alu_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_EMIT
    } t_seq_op;

    // One control word of the microprogram
    typedef struct packed {
        logic             mul_en;
        t_coef_sel        coef;
        t_src_sel         src;
        t_alu_op          alu;
        t_seq_op          seq;
        logic [UPC_W-1:0] target;
    } t_uword;

    // Microcode ROM: one section per pass, looped once for section two
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{mul_en: 1'b0, coef: COEF_B0, src: SRC_X, alu: ALU_NOP,
              seq: SEQ_NEXT, target: STEP_MUL_B0};
        case (pc)
            STEP_MUL_B0: begin
                w.mul_en = 1'b1;
                w.coef   = COEF_B0;
                w.src    = SRC_X;
            end
            STEP_ACC: begin
                w.alu = ALU_ACC;
            end
            STEP_ROUND: begin
                w.alu = ALU_ROUND;
            end
            STEP_MUL_A1: begin
                w.mul_en = 1'b1;
                w.coef   = COEF_A1;
                w.src    = SRC_Y;
            end
            STEP_FB1: begin
                w.mul_en = 1'b1;
                w.coef   = COEF_A2;
                w.src    = SRC_Y;
                w.alu    = ALU_FB1;
            end
            STEP_FB2: begin
                w.alu    = ALU_FB2;
                w.seq    = SEQ_LOOP;
                w.target = STEP_MUL_B0;
            end
            STEP_EMIT: begin
                w.seq = SEQ_EMIT;
            end
            default: begin
                w.seq = SEQ_EMIT;
            end
        endcase
        return w;
    endfunction

    // 64-bit add that clamps on overflow
    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/fourth_order_biquad_cascade_lowpass_unit.sv
// Two-section TDF-II lowpass cascade run by a microcoded sequencer over one multiplier.
// Filtering: two passes of 6 microsteps plus an emit step per item;
// next item stalled until the result is emitted, as all steps share the one multiplier.
// Pass-through (enable clear): the item goes straight to the emit step.
// Clear item: no result. A result still waiting at the output holds the emit step.
// Synchronous active-low reset zeroes enable, taps, delays and all handshake state.
`timescale 1ns / 1ps
`default_nettype none

module fourth_order_biquad_cascade_lowpass_unit #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 29,
    parameter int DELAY_WIDTH    = 40
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [fobq_pkg::REG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [fobq_pkg::COEF_WIDTH-1:0]     i_cfg_data,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_operation,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]           o_sample_out
);

    localparam int SH   = COEF_FRAC_BITS - fobq_pkg::GUARD_BITS;
    localparam int PW   = fobq_pkg::COEF_WIDTH + SAMPLE_WIDTH;
    localparam int CW   = fobq_pkg::COEF_WIDTH;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (fobq_pkg::GUARD_BITS - 1);
    localparam logic signed [63:0] SAMPLE_HI  = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAMPLE_LO  = -SAMPLE_HI - 64'sd1;
    localparam logic signed [63:0] DELAY_HI   = (64'sd1 <<< (DELAY_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] DELAY_LO   = -DELAY_HI - 64'sd1;

    // Clamp helpers
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [63:0] v);
        if (v > SAMPLE_HI) return SAMPLE_WIDTH'(SAMPLE_HI);
        if (v < SAMPLE_LO) return SAMPLE_WIDTH'(SAMPLE_LO);
        return SAMPLE_WIDTH'(v);
    endfunction

    function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(input logic signed [63:0] v);
        if (v > DELAY_HI) return DELAY_WIDTH'(DELAY_HI);
        if (v < DELAY_LO) return DELAY_WIDTH'(DELAY_LO);
        return DELAY_WIDTH'(v);
    endfunction

    // Configuration and state
    logic                                r_enable;
    logic signed [CW-1:0]                r_b0 [2];
    logic signed [CW-1:0]                r_a1 [2];
    logic signed [CW-1:0]                r_a2 [2];
    logic signed [DELAY_WIDTH-1:0]       r_z1 [2];
    logic signed [DELAY_WIDTH-1:0]       r_z2 [2];

    // Sequencer
    logic                                r_run;
    logic [fobq_pkg::UPC_W-1:0]          r_pc;
    logic                                r_sec;

    // Datapath registers
    logic signed [SAMPLE_WIDTH-1:0]      r_x;
    logic signed [SAMPLE_WIDTH-1:0]      r_y;
    logic signed [PW-1:0]                r_prod;
    logic signed [63:0]                  r_bx;
    logic signed [63:0]                  r_b1x;
    logic signed [63:0]                  r_acc;
    logic signed [63:0]                  r_t;
    logic                                r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]      r_out_data;

    fobq_pkg::t_uword                    w_uw;
    logic signed [CW-1:0]                w_mcoef;
    logic signed [SAMPLE_WIDTH-1:0]      w_msrc;
    logic signed [63:0]                  w_p64;
    logic signed [63:0]                  w_pq;
    logic signed [63:0]                  w_pq1;
    logic signed [63:0]                  w_z1;
    logic signed [63:0]                  w_z2;
    logic signed [63:0]                  w_rnd;
    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_cfg_coef;

    // Control word fetch and operand selection
    always_comb begin
        w_uw = fobq_pkg::ucode(r_pc);
        case (w_uw.coef)
            fobq_pkg::COEF_B0: w_mcoef = r_b0[r_sec];
            fobq_pkg::COEF_A1: w_mcoef = r_a1[r_sec];
            fobq_pkg::COEF_A2: w_mcoef = r_a2[r_sec];
            default:           w_mcoef = r_b0[r_sec];
        endcase
        w_msrc = (w_uw.src == fobq_pkg::SRC_Y) ? r_y : r_x;
    end

    // Product scaling and delay reads
    assign w_p64 = 64'(r_prod);
    assign w_pq  = w_p64 >>> SH;
    assign w_pq1 = w_p64 >>> (SH - 1);
    assign w_z1  = 64'(r_z1[r_sec]);
    assign w_z2  = 64'(r_z2[r_sec]);
    assign w_rnd = fobq_pkg::add_sat64(r_acc, ROUND_HALF) >>> fobq_pkg::GUARD_BITS;

    assign w_accept   = i_in_valid && !r_run;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_coef = i_cfg_we && (i_cfg_addr inside {[fobq_pkg::REG_FIRST_B0:
                                                          fobq_pkg::REG_SECOND_A2]});

    // Control state, configuration and delays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_pc        <= fobq_pkg::STEP_MUL_B0;
            r_sec       <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_b0[i] <= '0;
                r_a1[i] <= '0;
                r_a2[i] <= '0;
                r_z1[i] <= '0;
                r_z2[i] <= '0;
            end
        end else begin
            // Result slot drains on a taken item
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes; a tap write clears every delay
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    fobq_pkg::REG_ENABLE:    r_enable <= i_cfg_data[0];
                    fobq_pkg::REG_FIRST_B0:  r_b0[0]  <= i_cfg_data;
                    fobq_pkg::REG_FIRST_A1:  r_a1[0]  <= i_cfg_data;
                    fobq_pkg::REG_FIRST_A2:  r_a2[0]  <= i_cfg_data;
                    fobq_pkg::REG_SECOND_B0: r_b0[1]  <= i_cfg_data;
                    fobq_pkg::REG_SECOND_A1: r_a1[1]  <= i_cfg_data;
                    fobq_pkg::REG_SECOND_A2: r_a2[1]  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_cfg_coef) begin
                for (int i = 0; i < 2; i++) begin
                    r_z1[i] <= '0;
                    r_z2[i] <= '0;
                end
            end

            // Dispatch of an accepted item
            if (w_accept) begin
                if (i_operation == fobq_pkg::OP_CLEAR) begin
                    for (int i = 0; i < 2; i++) begin
                        r_z1[i] <= '0;
                        r_z2[i] <= '0;
                    end
                end else begin
                    r_run <= 1'b1;
                    r_sec <= 1'b0;
                    r_pc  <= r_enable ? fobq_pkg::STEP_MUL_B0 : fobq_pkg::STEP_EMIT;
                end
            end

            // Microprogram sequencing
            if (r_run) begin
                if (w_uw.alu == fobq_pkg::ALU_FB2) begin
                    r_z1[r_sec] <= sat_delay(fobq_pkg::add_sat64(r_t, w_z2));
                    r_z2[r_sec] <= sat_delay(r_bx - w_pq);
                end
                case (w_uw.seq)
                    fobq_pkg::SEQ_NEXT: r_pc <= r_pc + 1'b1;
                    fobq_pkg::SEQ_LOOP: begin
                        if (!r_sec) begin
                            r_sec <= 1'b1;
                            r_pc  <= w_uw.target;
                        end else begin
                            r_pc <= r_pc + 1'b1;
                        end
                    end
                    fobq_pkg::SEQ_EMIT: begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_run       <= 1'b0;
                        end
                    end
                    default: r_pc <= r_pc + 1'b1;
                endcase
            end
        end
    end

    // Datapath: shared multiplier and one add/clamp per step
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample_in;
            r_y <= i_sample_in;
        end
        if (r_run) begin
            if (w_uw.mul_en) begin
                r_prod <= PW'(w_mcoef) * PW'(w_msrc);
            end
            case (w_uw.alu)
                fobq_pkg::ALU_ACC: begin
                    r_bx  <= w_pq;
                    r_b1x <= w_pq1;
                    r_acc <= fobq_pkg::add_sat64(w_z1, w_pq);
                end
                fobq_pkg::ALU_ROUND: r_y <= sat_sample(w_rnd);
                fobq_pkg::ALU_FB1:   r_t <= r_b1x - w_pq;
                fobq_pkg::ALU_FB2:   r_x <= r_y;
                default: ;
            endcase
            if (w_uw.seq == fobq_pkg::SEQ_EMIT && w_out_free) begin
                r_out_data <= r_y;
            end
        end
    end

    assign o_in_stall   = r_run;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

`ifndef ASSERT_OFF
    // Emit step with a free slot must raise the result
    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run && r_pc == fobq_pkg::STEP_EMIT && w_out_free |=> r_out_valid && !r_run)
        else $error("emit step did not produce a result");

    // Program counter stays within the microprogram while running
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> r_pc <= fobq_pkg::STEP_EMIT)
        else $error("microprogram counter out of range");

    // A clear item never starts the sequencer and zeroes the delays
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_operation == fobq_pkg::OP_CLEAR
        |=> !r_run && r_z1[0] == '0 && r_z2[1] == '0)
        else $error("clear item started work or left delays");

    // Pass-through items go straight to the emit step
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_operation == fobq_pkg::OP_FILTER && !r_enable
        |=> r_run && r_pc == fobq_pkg::STEP_EMIT)
        else $error("pass-through item entered the filter program");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the two-section biquad cascade lowpass unit.
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_W     = 24;
    localparam int COEF_FRAC    = 29;
    localparam int DELAY_W      = 40;
    localparam int TAP_SHIFT    = COEF_FRAC - fobq_pkg::GUARD_BITS;
    localparam int SETTLE_WAIT  = 24;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [fobq_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [31:0] TAP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TAP_MIN = 32'sh8000_0000;
    localparam longint WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint WIDE_MIN = 64'sh8000_0000_0000_0000;

    // Butterworth sections for a cutoff at a tenth of the sample rate, Q3.29
    localparam logic signed [31:0] BW1_B0 = 32'sd33227000;
    localparam logic signed [31:0] BW1_A1 = -32'sd562963000;
    localparam logic signed [31:0] BW1_A2 = 32'sd159022000;
    localparam logic signed [31:0] BW2_B0 = 32'sd41849000;
    localparam logic signed [31:0] BW2_A1 = -32'sd709152000;
    localparam logic signed [31:0] BW2_A2 = 32'sd339678000;

    typedef struct {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_sample_item;

    typedef enum int {
        RUN_STEP,
        RUN_EXTREME,
        RUN_SMALL,
        RUN_WIDE
    } t_run_shape;

    // DUT connections, all driven from time zero
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [fobq_pkg::REG_IDX_W-1:0] i_cfg_addr = fobq_pkg::REG_ENABLE;
    logic [fobq_pkg::COEF_WIDTH-1:0] i_cfg_data = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          i_operation = fobq_pkg::OP_FILTER;
    logic signed [SAMPLE_W-1:0]    i_sample_in = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [SAMPLE_W-1:0]    o_sample_out;

    // Predictor state
    logic                          filter_on;
    logic signed [31:0]            tap_b0 [2];
    logic signed [31:0]            tap_a1 [2];
    logic signed [31:0]            tap_a2 [2];
    longint                        state_z1 [2];
    longint                        state_z2 [2];

    t_sample_item                  pending_items [$];
    logic signed [SAMPLE_W-1:0]    sample_expect [$];

    int                            send_gap     = 0;
    int                            stall_left   = 0;
    int                            quiet_cycles = 0;
    int                            fail_count   = 0;
    bit                            idling_on    = 1'b1;

    fourth_order_biquad_cascade_lowpass_unit #(
        .SAMPLE_WIDTH   (SAMPLE_W),
        .COEF_FRAC_BITS (COEF_FRAC),
        .DELAY_WIDTH    (DELAY_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Filter arithmetic
    // ---------------------------------------------------------------
    function automatic longint sum_clamped(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0) return WIDE_MAX;
        if (a < 0 && b < 0 && s >= 0) return WIDE_MIN;
        return s;
    endfunction

    function automatic longint clamp_bits(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One TDF-II section; updates that section's delays
    function automatic longint run_biquad(input int s, input longint x);
        longint prod, bx, b1x, acc, y, a1y, a2y;
        prod = longint'(tap_b0[s]) * x;
        bx   = prod >>> TAP_SHIFT;
        b1x  = prod >>> (TAP_SHIFT - 1);
        acc  = sum_clamped(state_z1[s], bx);
        y    = clamp_bits(sum_clamped(acc, longint'(1) <<< (fobq_pkg::GUARD_BITS - 1))
                          >>> fobq_pkg::GUARD_BITS, SAMPLE_W);
        a1y  = (longint'(tap_a1[s]) * y) >>> TAP_SHIFT;
        a2y  = (longint'(tap_a2[s]) * y) >>> TAP_SHIFT;
        state_z1[s] = clamp_bits(sum_clamped(b1x - a1y, state_z2[s]), DELAY_W);
        state_z2[s] = clamp_bits(bx - a2y, DELAY_W);
        return y;
    endfunction

    function automatic void zero_delays();
        for (int s = 0; s < 2; s++) begin
            state_z1[s] = 0;
            state_z2[s] = 0;
        end
    endfunction

    // Work out what one accepted item yields
    function automatic void predict_item(input logic op, input logic signed [SAMPLE_W-1:0] x);
        longint y;
        if (op == fobq_pkg::OP_CLEAR) begin
            zero_delays();
            return;
        end
        y = longint'(x);
        if (filter_on) begin
            y = run_biquad(0, y);
            y = run_biquad(1, y);
        end
        sample_expect.insert(sample_expect.size(), y[SAMPLE_W-1:0]);
    endfunction

    function automatic void apply_reg(input logic [fobq_pkg::REG_IDX_W-1:0] idx,
                                      input logic [31:0] val);
        case (idx)
            fobq_pkg::REG_ENABLE:    filter_on = val[0];
            fobq_pkg::REG_FIRST_B0:  begin tap_b0[0] = val; zero_delays(); end
            fobq_pkg::REG_FIRST_A1:  begin tap_a1[0] = val; zero_delays(); end
            fobq_pkg::REG_FIRST_A2:  begin tap_a2[0] = val; zero_delays(); end
            fobq_pkg::REG_SECOND_B0: begin tap_b0[1] = val; zero_delays(); end
            fobq_pkg::REG_SECOND_A1: begin tap_a1[1] = val; zero_delays(); end
            fobq_pkg::REG_SECOND_A2: begin tap_a2[1] = val; zero_delays(); end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [fobq_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        apply_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_enable(input logic en);
        write_reg(fobq_pkg::REG_ENABLE, ($urandom & 32'hFFFF_FFFE) | {31'd0, en});
    endtask

    task automatic program_filter(input logic en,
                                  input logic [31:0] fb0, input logic [31:0] fa1,
                                  input logic [31:0] fa2, input logic [31:0] sb0,
                                  input logic [31:0] sa1, input logic [31:0] sa2);
        write_reg(fobq_pkg::REG_FIRST_B0, fb0);
        write_reg(fobq_pkg::REG_FIRST_A1, fa1);
        write_reg(fobq_pkg::REG_FIRST_A2, fa2);
        write_reg(fobq_pkg::REG_SECOND_B0, sb0);
        write_reg(fobq_pkg::REG_SECOND_A1, sa1);
        write_reg(fobq_pkg::REG_SECOND_A2, sa2);
        write_enable(en);
    endtask

    task automatic queue_item(input logic op, input logic signed [SAMPLE_W-1:0] x);
        t_sample_item it;
        it.op     = op;
        it.sample = x;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Runs of steps, square waves at full scale, small noise and wide noise
    task automatic queue_random(input int count);
        int                         left, run_len, k;
        t_run_shape                 shape;
        logic signed [SAMPLE_W-1:0] level;
        left = count;
        while (left > 0) begin
            run_len = $urandom_range(1, 12);
            shape   = t_run_shape'($urandom_range(0, 3));
            level   = SAMPLE_W'($urandom);
            if (shape == RUN_EXTREME) level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            for (k = 0; k < run_len && left > 0; k++) begin
                if ($urandom_range(0, 23) == 0) begin
                    queue_item(fobq_pkg::OP_CLEAR, SAMPLE_W'($urandom));
                end else begin
                    case (shape)
                        RUN_STEP: queue_item(fobq_pkg::OP_FILTER,
                                      SAMPLE_W'(int'(level) + int'($urandom_range(0, 6)) - 3));
                        RUN_EXTREME: begin
                            queue_item(fobq_pkg::OP_FILTER, level);
                            level = ~level;
                        end
                        RUN_SMALL: queue_item(fobq_pkg::OP_FILTER,
                                       SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048));
                        default:   queue_item(fobq_pkg::OP_FILTER, SAMPLE_W'($urandom));
                    endcase
                end
                left--;
            end
        end
    endtask

    // Sender holds off until every expected result is back and the unit is quiet
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || sample_expect.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Input driver and predictor hook
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        t_sample_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_item(i_operation, i_sample_in);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    send_gap   <= $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    it = pending_items.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= it.op;
                    i_sample_in <= it.sample;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker and output stall
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (sample_expect.size() == 0) begin
                    fail_count++;
                    $display("%0t: sample_out unexpected, expected no item, got %0d",
                             $time, o_sample_out);
                end else begin
                    want = sample_expect.pop_front();
                    if (o_sample_out !== want) begin
                        fail_count++;
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, o_sample_out);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left  <= $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Count cycles with no handshake on any port
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sample_expect.size());
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        filter_on = 1'b0;
        for (int s = 0; s < 2; s++) begin
            tap_b0[s] = '0;
            tap_a1[s] = '0;
            tap_a2[s] = '0;
        end
        zero_delays();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset state: filtering off, samples pass through, clear gives nothing
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MAX);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MIN);
        queue_item(fobq_pkg::OP_FILTER, '0);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_W'(-1));
        queue_item(fobq_pkg::OP_CLEAR, SAMPLE_MAX);
        queue_item(fobq_pkg::OP_FILTER, 24'h555555);
        queue_item(fobq_pkg::OP_FILTER, 24'hAAAAAA);
        wait_idle();

        // Butterworth taps: impulse, full-scale steps, clears mid-stream
        program_filter(1'b1, BW1_B0, BW1_A1, BW1_A2, BW2_B0, BW2_A1, BW2_A2);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MAX);
        queue_item(fobq_pkg::OP_FILTER, '0);
        queue_item(fobq_pkg::OP_FILTER, '0);
        queue_item(fobq_pkg::OP_FILTER, '0);
        queue_item(fobq_pkg::OP_CLEAR, '0);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MIN);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MIN);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MIN);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_W'(1));
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_W'(-1));
        queue_item(fobq_pkg::OP_CLEAR, SAMPLE_MIN);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MAX);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MIN);
        queue_random(300);
        wait_idle();

        // Rewriting one tap with the same value still wipes the delays;
        // a write to the unused index changes nothing
        queue_random(30);
        wait_idle();
        write_reg(fobq_pkg::REG_FIRST_A2, BW1_A2);
        write_reg(REG_UNUSED, $urandom);
        queue_random(30);
        wait_idle();

        // Enable toggles leave the delays alone; clear still works while off
        write_enable(1'b0);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MAX);
        queue_item(fobq_pkg::OP_CLEAR, '0);
        queue_item(fobq_pkg::OP_FILTER, SAMPLE_MIN);
        queue_random(60);
        wait_idle();
        write_enable(1'b1);
        queue_random(60);
        wait_idle();

        // Extreme taps drive sections and delays into saturation
        program_filter(1'b1, TAP_MAX, TAP_MIN, TAP_MAX, TAP_MIN, TAP_MAX, TAP_MIN);
        queue_random(120);
        wait_idle();
        program_filter(1'b1, TAP_MIN, TAP_MAX, TAP_MIN, TAP_MAX, TAP_MIN, TAP_MAX);
        queue_random(80);
        wait_idle();
        program_filter(1'b1, '0, '0, '0, '0, '0, '0);
        queue_random(30);
        wait_idle();

        // Random taps, some scaled down towards stable filters
        repeat (3) begin
            program_filter(1'b1,
                           $signed($urandom) >>> $urandom_range(0, 6),
                           $signed($urandom) >>> $urandom_range(0, 2),
                           $signed($urandom) >>> $urandom_range(0, 3),
                           $urandom,
                           $signed($urandom) >>> $urandom_range(0, 2),
                           $signed($urandom) >>> $urandom_range(0, 3));
            queue_random(80);
            wait_idle();
        end

        // Final stretch at full rate
        program_filter(1'b1, BW1_B0, BW1_A1, BW1_A2, BW2_B0, BW2_A1, BW2_A2);
        idling_on = 1'b0;
        queue_random(200);
        wait_idle();

        if (fail_count == 0 && sample_expect.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
